[design/pulse_formant_biquad_cascade_top_defines.svh]
`ifndef PULSE_FORMANT_BIQUAD_CASCADE_TOP_DEFINES_SVH
`define PULSE_FORMANT_BIQUAD_CASCADE_TOP_DEFINES_SVH
`ifndef SYNTH
`define PFBC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("pfbc assertion failed");
`define PFBC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("pfbc assertion failed");
`else
`define PFBC_ASSERT(lbl, prop)
`define PFBC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[design/pfbc_pkg.sv]
`default_nettype none
package pfbc_pkg;

	localparam int NUM_FORMANTS = 5;
	localparam int NUM_REGS     = NUM_FORMANTS + 1;
	localparam int CFG_IDX_W    = $clog2(NUM_REGS + 1);
	localparam int CFG_DATA_W   = 54;
	localparam int COEF_W       = 18;
	localparam int STATE_W      = 32;
	localparam int PHASE_W      = 32;
	localparam int OUT_W        = 24;
	localparam int PROD_W       = COEF_W + STATE_W;
	localparam int ACC_W        = PROD_W + 2;
	localparam int FRAC_SH      = 16;
	localparam int SCALE_W      = 16;
	localparam int SCPROD_W     = STATE_W + SCALE_W;
	localparam int OUT_SH       = 20;

	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE  = CFG_IDX_W'(1);

	localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd39370534;
	localparam logic [PHASE_W-1:0] PULSE_THRESHOLD  = 32'd429496730;
	localparam logic signed [STATE_W-1:0] PULSE_HIGH = 32'sd16777216;
	localparam logic signed [STATE_W-1:0] PULSE_LOW  = -32'sd2516582;
	localparam logic signed [SCALE_W-1:0] OUT_SCALE  = 16'sd22938;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	typedef struct packed {
		logic                      vld;
		logic signed [STATE_W-1:0] x;
	} link_t;

	function automatic logic signed [STATE_W-1:0] round_q24(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-1:0] sh;
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		t  = acc + (ACC_W'(1) <<< (FRAC_SH - 1));
		sh = t >>> FRAC_SH;
		hi = ACC_W'({1'b0, {(STATE_W-1){1'b1}}});
		lo = -hi - ACC_W'(1);
		if (sh > hi) begin
			round_q24 = hi[STATE_W-1:0];
		end else if (sh < lo) begin
			round_q24 = lo[STATE_W-1:0];
		end else begin
			round_q24 = sh[STATE_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

[design/pulse_formant_biquad_cascade_top.sv]
// path: an accepted input passes start_q, each section cell in turn, the output scale register,
// the pending register and the output register; each section cell registers its forward
// path (b0 multiply, then round) before handing off to the next
// a new input is taken once the previous result sits in the output register
// reset: async active low, phase and filter states zero, phase_step to its default,
// coefficients zero
`default_nettype none
`include "pulse_formant_biquad_cascade_top_defines.svh"
module pulse_formant_biquad_cascade_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                clear_first,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [pfbc_pkg::OUT_W-1:0]        sample_out,
	input  wire logic                                cfg_we,
	input  wire logic [pfbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pfbc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pfbc_pkg::*;

	logic [PHASE_W-1:0]          phase_step_q;
	coef_t                       coef_q [NUM_FORMANTS];
	logic [PHASE_W-1:0]          phase_q;
	logic                        busy_q;
	logic                        start_q;
	logic                        sc_vld_s1;
	logic signed [SCPROD_W-1:0]  sc_s1;
	logic                        pend_q;
	logic signed [OUT_W-1:0]     pend_val_q;
	logic                        out_valid_q;
	logic signed [OUT_W-1:0]     sample_q;

	logic                        accept;
	logic                        clear;
	logic                        push;
	link_t                       link [NUM_FORMANTS+1];
	logic [NUM_FORMANTS-1:0]     cell_vld;
	logic signed [STATE_W-1:0]   y_last;
	logic signed [SCPROD_W-1:0]  sc_d;
	logic signed [SCPROD_W-1:0]  sc_rnd;
	logic signed [SCPROD_W-1:0]  out_hi, out_lo;
	logic signed [OUT_W-1:0]     out_sat;

	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign clear    = accept && clear_first;
	assign push     = pend_q && (!out_valid_q || out_ready);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= PHASE_STEP_RESET;
			for (int k = 0; k < NUM_FORMANTS; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_PHASE_STEP) begin
				phase_step_q <= cfg_data[PHASE_W-1:0];
			end
			for (int k = 0; k < NUM_FORMANTS; k++) begin
				if (cfg_index == REG_COEF_BASE + CFG_IDX_W'(k)) begin
					coef_q[k] <= coef_t'(cfg_data[3*COEF_W-1:0]);
				end
			end
		end
	end

	// phase accumulator and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			busy_q      <= 1'b0;
			start_q     <= 1'b0;
			sc_vld_s1   <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q   <= accept;
			sc_vld_s1 <= link[NUM_FORMANTS].vld;
			if (accept) begin
				phase_q <= (clear_first ? '0 : phase_q) + phase_step_q;
				busy_q  <= 1'b1;
			end else if (push) begin
				busy_q <= 1'b0;
			end
			if (sc_vld_s1) begin
				pend_q <= 1'b1;
			end else if (push) begin
				pend_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign link[0].vld = start_q;
	assign link[0].x   = (phase_q < PULSE_THRESHOLD) ? PULSE_HIGH : PULSE_LOW;

	for (genvar k = 0; k < NUM_FORMANTS; k++) begin : g_cell
		pfbc_biquad_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.clear  (clear),
			.coef   (coef_q[k]),
			.din    (link[k]),
			.dout   (link[k+1])
		);
		assign cell_vld[k] = link[k+1].vld;
	end

	// output scale and saturation
	assign y_last = link[NUM_FORMANTS].x;
	assign sc_d   = y_last * OUT_SCALE;
	assign sc_rnd = (sc_s1 + (SCPROD_W'(1) <<< (OUT_SH - 1))) >>> OUT_SH;
	assign out_hi = SCPROD_W'({1'b0, {(OUT_W-1){1'b1}}});
	assign out_lo = -out_hi - SCPROD_W'(1);

	always_comb begin
		if (sc_rnd > out_hi) begin
			out_sat = out_hi[OUT_W-1:0];
		end else if (sc_rnd < out_lo) begin
			out_sat = out_lo[OUT_W-1:0];
		end else begin
			out_sat = sc_rnd[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (link[NUM_FORMANTS].vld) begin
			sc_s1 <= sc_d;
		end
		if (sc_vld_s1) begin
			pend_val_q <= out_sat;
		end
		if (push) begin
			sample_q <= pend_val_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;

	`PFBC_ASSERT_NEXT(a_accept_blocks, in_valid && in_ready, !in_ready)
	`PFBC_ASSERT(a_one_in_flight, $onehot0({start_q, cell_vld, sc_vld_s1, pend_q}))
	`PFBC_ASSERT_NEXT(a_pend_held, pend_q && out_valid_q && !out_ready, pend_q)
	`PFBC_ASSERT(a_idle_empty, !busy_q |-> !(start_q || sc_vld_s1 || pend_q))

endmodule
`default_nettype wire

[design/pfbc_biquad_cell.sv]
`default_nettype none
module pfbc_biquad_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           clear,
	input  wire pfbc_pkg::coef_t coef,
	input  wire pfbc_pkg::link_t din,
	output pfbc_pkg::link_t     dout
);
	import pfbc_pkg::*;

	logic                      v1_q, v2_q, v3_q;
	logic signed [PROD_W-1:0]  bx_q;
	logic signed [STATE_W-1:0] y_q;
	logic signed [PROD_W-1:0]  p1_q, p2_q;
	logic signed [STATE_W-1:0] s1_q, s2_q;

	logic signed [COEF_W-1:0]  b0, a1, a2;
	logic signed [STATE_W-1:0] xin;
	logic signed [PROD_W-1:0]  bx_d, p1_d, p2_d;
	logic signed [ACC_W-1:0]   acc_y, acc_s1, acc_s2;

	assign b0  = coef.b0;
	assign a1  = coef.a1;
	assign a2  = coef.a2;
	assign xin = din.x;

	assign bx_d = b0 * xin;
	assign p1_d = a1 * y_q;
	assign p2_d = a2 * y_q;

	assign acc_y  = $signed({{(ACC_W-PROD_W){bx_q[PROD_W-1]}}, bx_q})
		+ $signed({{(ACC_W-STATE_W-FRAC_SH){s1_q[STATE_W-1]}}, s1_q, {FRAC_SH{1'b0}}});
	assign acc_s1 = $signed({{(ACC_W-STATE_W-FRAC_SH){s2_q[STATE_W-1]}}, s2_q, {FRAC_SH{1'b0}}})
		- $signed({{(ACC_W-PROD_W){p1_q[PROD_W-1]}}, p1_q});
	assign acc_s2 = -$signed({{(ACC_W-PROD_W){bx_q[PROD_W-1]}}, bx_q})
		- $signed({{(ACC_W-PROD_W){p2_q[PROD_W-1]}}, p2_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			s1_q <= '0;
			s2_q <= '0;
		end else begin
			v1_q <= din.vld;
			v2_q <= v1_q;
			v3_q <= v2_q;
			if (clear) begin
				s1_q <= '0;
				s2_q <= '0;
			end else if (v3_q) begin
				s1_q <= round_q24(acc_s1);
				s2_q <= round_q24(acc_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (din.vld) begin
			bx_q <= bx_d;
		end
		if (v1_q) begin
			y_q <= round_q24(acc_y);
		end
		if (v2_q) begin
			p1_q <= p1_d;
			p2_q <= p2_d;
		end
	end

	assign dout.vld = v2_q;
	assign dout.x   = y_q;

endmodule
`default_nettype wire
